// ===== design/three_pot_signal_finder_top_macros.svh =====
// Assertion helpers for the signal finder
`ifndef THREE_POT_SIGNAL_FINDER_TOP_MACROS_SVH
`define THREE_POT_SIGNAL_FINDER_TOP_MACROS_SVH

// condition in the same cycle
`define TPSF_ASSERT_NOW(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("tpsf assertion failed");

// condition in the next cycle
`define TPSF_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("tpsf assertion failed");

`endif

// ===== design/tpsf_pkg.sv =====
package tpsf_pkg;

    localparam int unsigned LEVEL_W  = 8;
    localparam int unsigned SENSOR_W = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_START     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POT_FLOOR     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POT_CENTRE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_BUDGET = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_CENTRE = 3'd5;

    localparam logic [LEVEL_W-1:0]  RST_TOP_START     = 8'd255;
    localparam logic [LEVEL_W-1:0]  RST_POT_FLOOR     = 8'd0;
    localparam logic [LEVEL_W-1:0]  RST_POT_CENTRE    = 8'd128;
    localparam logic [LEVEL_W-1:0]  RST_GAP_LIMIT     = 8'd4;
    localparam logic [SENSOR_W-1:0] RST_SAMPLE_BUDGET = 16'd1024;
    localparam logic [SENSOR_W-1:0] RST_SENSOR_CENTRE = 16'd32768;

    localparam logic ACT_START  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // reported phase codes
    localparam logic [1:0] PHASE_CODE_IDLE   = 2'd0;
    localparam logic [1:0] PHASE_CODE_COARSE = 2'd1;
    localparam logic [1:0] PHASE_CODE_FINE   = 2'd2;
    localparam logic [1:0] PHASE_CODE_SETTLE = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_COARSE = 4'b0010,
        PH_FINE   = 4'b0100,
        PH_SETTLE = 4'b1000
    } t_phase;

    typedef enum logic [1:0] {
        SIDE_NONE = 2'd0,
        SIDE_LOW  = 2'd1,
        SIDE_HIGH = 2'd2
    } t_side;

    typedef struct packed {
        logic                action;
        logic [SENSOR_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] top_level;
        logic [LEVEL_W-1:0] bottom_level;
        logic [LEVEL_W-1:0] mid_level;
        logic [1:0]         phase;
        logic               done_res;
    } t_out_item;

endpackage

// ===== design/three_pot_signal_finder_top.sv =====
// Three-level signal finder.
// Input channel (i_valid / o_stall, payload i_in): action start loads the
// top, bottom and mid levels from the configuration; action sample advances
// the coarse, fine or settling step of the search by one sample.
// Output channel (o_valid / i_stall, payload o_out): exactly one result per
// accepted item, carrying the levels and phase after that item and a done flag.
// A result is registered in r_out, or in the skid register on a stall.
// Throughput is one item per cycle while o_stall is low; the search state
// updates in the same cycle the item is taken, so consecutive samples
// chain without bubbles. When the receiver stalls, one more item is taken
// into a skid register and o_stall then rises until the held result moves on.
// Configuration: i_cfg_wr_en, i_cfg_index, i_cfg_data; write only while idle.
// Reset (synchronous, i_rst_n low) restores the register defaults, clears
// the levels to zero, sets the phase to idle and empties the output stages.
`include "three_pot_signal_finder_top_macros.svh"

module three_pot_signal_finder_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  tpsf_pkg::t_in_item                  i_in,
    output logic                                o_valid,
    input  logic                                i_stall,
    output tpsf_pkg::t_out_item                 o_out,
    input  logic                                i_cfg_wr_en,
    input  logic [tpsf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tpsf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import tpsf_pkg::*;

    // configuration
    logic [LEVEL_W-1:0]  r_top_start, r_pot_floor, r_pot_centre, r_gap_limit;
    logic [SENSOR_W-1:0] r_sample_budget, r_sensor_centre;

    // search state
    t_phase              r_phase, n_phase;
    t_side               r_first_side, n_first_side;
    logic [LEVEL_W-1:0]  r_top, n_top, r_bottom, n_bottom, r_mid, n_mid;
    logic                r_seen, n_seen;
    logic [SENSOR_W-1:0] r_samples, n_samples, r_last_dist, n_last_dist;
    logic [1:0]          r_settle_left, n_settle_left;
    logic                n_done;

    // output stages
    t_out_item r_out, r_skid, n_result;
    logic      r_out_valid, r_skid_valid;

    logic accept, out_take;
    logic side_low;
    t_side side, fs;
    logic [SENSOR_W-1:0] sample_dist;
    logic [LEVEL_W-1:0]  mid_up, mid_down;
    logic [LEVEL_W:0]    mid_diff;
    logic [LEVEL_W-1:0]  mid_abs;
    logic [1:0]          drag;
    logic [LEVEL_W-1:0]  drag_ext;
    logic [LEVEL_W-1:0]  mid_dragged;
    logic                coarse_go;
    logic [1:0]          phase_code;

    assign accept   = i_valid && !o_stall;
    assign out_take = r_out_valid && !i_stall;
    assign o_stall  = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_out    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_start     <= RST_TOP_START;
            r_pot_floor     <= RST_POT_FLOOR;
            r_pot_centre    <= RST_POT_CENTRE;
            r_gap_limit     <= RST_GAP_LIMIT;
            r_sample_budget <= RST_SAMPLE_BUDGET;
            r_sensor_centre <= RST_SENSOR_CENTRE;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_TOP_START:     r_top_start     <= i_cfg_data[LEVEL_W-1:0];
                CFG_POT_FLOOR:     r_pot_floor     <= i_cfg_data[LEVEL_W-1:0];
                CFG_POT_CENTRE:    r_pot_centre    <= i_cfg_data[LEVEL_W-1:0];
                CFG_GAP_LIMIT:     r_gap_limit     <= i_cfg_data[LEVEL_W-1:0];
                CFG_SAMPLE_BUDGET: r_sample_budget <= i_cfg_data;
                CFG_SENSOR_CENTRE: r_sensor_centre <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sample classification
    assign side_low    = i_in.sample < r_sensor_centre;
    assign side        = side_low ? SIDE_LOW : SIDE_HIGH;
    assign fs          = (r_first_side == SIDE_NONE) ? side : r_first_side;
    assign sample_dist = side_low ? (r_sensor_centre - i_in.sample)
                                  : (i_in.sample - r_sensor_centre);

    assign mid_up   = (r_mid == 8'hFF) ? r_mid : r_mid + 8'd1;
    assign mid_down = (r_mid == 8'h00) ? r_mid : r_mid - 8'd1;

    // drag mid toward the centre by clamp(|d|/4, 1, 3)
    assign mid_diff = {1'b0, r_mid} - {1'b0, r_pot_centre};
    assign mid_abs  = mid_diff[LEVEL_W] ? (r_pot_centre - r_mid) : mid_diff[LEVEL_W-1:0];
    always_comb begin
        if (mid_abs[LEVEL_W-1:2] == '0)
            drag = 2'd1;
        else if (mid_abs[LEVEL_W-1:4] != '0)
            drag = 2'd3;
        else
            drag = mid_abs[3:2];
    end
    assign drag_ext = {{(LEVEL_W-2){1'b0}}, drag};
    always_comb begin
        if (mid_diff[LEVEL_W])
            mid_dragged = (r_mid > 8'hFF - drag_ext) ? 8'hFF : r_mid + drag_ext;
        else
            mid_dragged = (r_mid < drag_ext) ? 8'h00 : r_mid - drag_ext;
    end

    always_comb begin
        n_phase       = r_phase;
        n_first_side  = r_first_side;
        n_top         = r_top;
        n_bottom      = r_bottom;
        n_mid         = r_mid;
        n_seen        = r_seen;
        n_samples     = r_samples;
        n_last_dist   = r_last_dist;
        n_settle_left = r_settle_left;
        n_done        = 1'b0;
        coarse_go     = 1'b0;

        if (i_in.action == ACT_START) begin
            n_top         = r_top_start;
            n_bottom      = r_pot_floor;
            n_mid         = r_pot_centre;
            n_first_side  = SIDE_NONE;
            n_seen        = 1'b0;
            n_samples     = '0;
            n_last_dist   = '0;
            n_settle_left = '0;
            coarse_go     = 1'b1;
        end else begin
            case (r_phase)
                PH_COARSE: begin
                    n_first_side = fs;
                    if (!r_seen) begin
                        if (side == fs)
                            n_mid = side_low ? mid_up : mid_down;
                        else
                            n_seen = 1'b1;
                    end else begin
                        if (side_low)
                            n_top = (r_top == 8'h00) ? r_top : r_top - 8'd1;
                        else
                            n_bottom = (r_bottom == 8'hFF) ? r_bottom : r_bottom + 8'd1;
                        if (r_mid != r_pot_centre)
                            n_mid = mid_dragged;
                    end
                    if (r_samples != '1)
                        n_samples = r_samples + 16'd1;
                    coarse_go = 1'b1;
                end
                PH_FINE: begin
                    n_first_side = fs;
                    if (side != fs) begin
                        if (sample_dist < r_last_dist) begin
                            n_mid         = side_low ? mid_down : mid_up;
                            n_settle_left = 2'd3;
                        end else begin
                            n_settle_left = 2'd2;
                        end
                        n_phase = PH_SETTLE;
                    end else begin
                        n_mid       = side_low ? mid_up : mid_down;
                        n_last_dist = sample_dist;
                    end
                end
                PH_SETTLE: begin
                    if (r_settle_left != 2'd0)
                        n_settle_left = r_settle_left - 2'd1;
                    if (r_settle_left <= 2'd1) begin
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        // gap and budget test after a start or a coarse sample
        if (coarse_go) begin
            if (n_top > n_bottom && (n_top - n_bottom) > r_gap_limit &&
                n_samples < r_sample_budget) begin
                n_phase = PH_COARSE;
            end else begin
                n_phase      = PH_FINE;
                n_first_side = SIDE_NONE;
                n_last_dist  = '0;
            end
        end
    end

    always_comb begin
        case (n_phase)
            PH_IDLE:   phase_code = PHASE_CODE_IDLE;
            PH_COARSE: phase_code = PHASE_CODE_COARSE;
            PH_FINE:   phase_code = PHASE_CODE_FINE;
            PH_SETTLE: phase_code = PHASE_CODE_SETTLE;
            default:   phase_code = PHASE_CODE_IDLE;
        endcase
    end

    assign n_result = '{top_level:    n_top,
                        bottom_level: n_bottom,
                        mid_level:    n_mid,
                        phase:        phase_code,
                        done_res:     n_done};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_first_side  <= SIDE_NONE;
            r_top         <= '0;
            r_bottom      <= '0;
            r_mid         <= '0;
            r_seen        <= 1'b0;
            r_samples     <= '0;
            r_last_dist   <= '0;
            r_settle_left <= '0;
        end else if (accept) begin
            r_phase       <= n_phase;
            r_first_side  <= n_first_side;
            r_top         <= n_top;
            r_bottom      <= n_bottom;
            r_mid         <= n_mid;
            r_seen        <= n_seen;
            r_samples     <= n_samples;
            r_last_dist   <= n_last_dist;
            r_settle_left <= n_settle_left;
        end
    end

    // output register plus skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid && out_take) begin
                r_skid_valid <= 1'b0;
            end else if (accept) begin
                r_out_valid <= 1'b1;
                if (r_out_valid && !out_take)
                    r_skid_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid && out_take)
            r_out <= r_skid;
        else if (accept && (!r_out_valid || out_take))
            r_out <= n_result;
        if (accept && r_out_valid && !out_take)
            r_skid <= n_result;
    end

    `TPSF_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `TPSF_ASSERT_NOW(a_done_is_idle, i_clk, i_rst_n, r_out_valid && r_out.done_res, r_out.phase == PHASE_CODE_IDLE)
    `TPSF_ASSERT_NEXT(a_start_enters_search, i_clk, i_rst_n, accept && i_in.action == ACT_START, r_phase == PH_COARSE || r_phase == PH_FINE)
    `TPSF_ASSERT_NOW(a_settle_count_in_settle, i_clk, i_rst_n, r_settle_left != 2'd0, r_phase == PH_SETTLE)

endmodule
